### rtl/core/gtr_pkg.sv
package gtr_pkg;

   // Action codes of an input item.
   localparam logic [1:0] ACT_LOAD     = 2'd0;
   localparam logic [1:0] ACT_DRAW_POS = 2'd1;
   localparam logic [1:0] ACT_DRAW_CUR = 2'd2;

   localparam logic [7:0] FIRST_CODE = 8'h20;
   localparam logic [7:0] END_CODE   = 8'h80;

   localparam int GLYPH_ROWS   = 7;
   localparam int GLYPH_COLS   = 5;
   localparam int CELL_ADVANCE = 6;
   localparam int LINE_ADVANCE = 8;
   localparam int Y_TOP        = 255;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAW
   } gtr_state_type;

   typedef struct packed {
      logic capture;
      logic fetch_en;
      logic draw_en;
   } gtr_cmd_type;

   typedef struct packed {
      logic start_draw;
      logic fetch_last;
      logic pixel_step;
      logic pixel_final;
   } gtr_sts_type;

endpackage

### rtl/core/gtr_ctrl.sv
module gtr_ctrl
   import gtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gtr_sts_type sts,
   output gtr_cmd_type cmd
);

   gtr_state_type state_ff;
   gtr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.start_draw) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (sts.fetch_last) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (sts.pixel_step && sts.pixel_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.fetch_en = 1'b0;
      cmd.draw_en  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_FETCH: begin
            cmd.fetch_en = 1'b1;
         end
         ST_DRAW: begin
            cmd.draw_en = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A draw always spends its fetch phase before any pixel is scanned.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (state_ff == ST_IDLE) || (state_ff == ST_FETCH))
      else $error("draw entered without fetch");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) && !sts.fetch_last |=> (state_ff == ST_FETCH))
      else $error("fetch phase left early");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW) && !sts.pixel_step |=> (state_ff == ST_DRAW))
      else $error("draw left while a pixel was stalled");

endmodule

### rtl/core/gtr_datapath.sv
module gtr_datapath
   import gtr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 255,
   parameter int SCREEN_HEIGHT = 64,
   parameter int GLYPH_COUNT   = 96
)
(
   input  logic              clock,
   input  logic              reset,
   input  gtr_cmd_type       cmd,
   output gtr_sts_type       sts,
   input  logic [1:0]        req_action,
   input  logic [8:0]        req_font_address,
   input  logic [7:0]        req_font_byte,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_fg_value,
   input  logic [7:0]        req_bg_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [13:0]       rsp_pixel_address,
   output logic [7:0]        rsp_pixel_value,
   output logic              rsp_last_pixel
);

   localparam int MEM_DEPTH = GLYPH_COUNT * GLYPH_COLS;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam logic [13:0] ROW_STEP = 14'(SCREEN_WIDTH - (GLYPH_COLS - 1));
   localparam logic [2:0]  LAST_COL = 3'(GLYPH_COLS - 1);
   localparam logic [2:0]  LAST_ROW = 3'(GLYPH_ROWS - 1);

   logic [7:0] glyph_mem [MEM_DEPTH];
   logic [7:0] rd_data_ff;

   logic signed [9:0] cursor_x_ff, cursor_x_in;
   logic signed [8:0] cursor_y_ff, cursor_y_in;

   logic [9:0]  x0_ff;
   logic [8:0]  y0_ff;
   logic [7:0]  fg_ff;
   logic [7:0]  bg_ff;
   logic [8:0]  glyph_base_ff;
   logic [7:0]  col_bits_ff [GLYPH_COLS];
   logic [2:0]  fetch_cnt_ff;
   logic [2:0]  row_ff;
   logic [2:0]  col_ff;
   logic [13:0] addr_ff;

   logic        rsp_valid_ff;
   logic [13:0] rsp_addr_ff;
   logic [7:0]  rsp_value_ff;
   logic        rsp_last_ff;

   // Decode of the item on the input ports.
   logic [7:0]  glyph_idx;
   logic        code_ok;
   logic        is_draw;
   logic [8:0]  glyph_base_in;
   logic [9:0]  x0_sel;
   logic [8:0]  y0_sel;
   logic [10:0] x_wrap_test;
   logic [9:0]  y_next;

   assign glyph_idx = req_char_code - FIRST_CODE;
   assign code_ok   = (req_char_code >= FIRST_CODE) && (req_char_code < END_CODE)
                      && (glyph_idx < 8'(GLYPH_COUNT));
   assign is_draw   = req_action inside {ACT_DRAW_POS, ACT_DRAW_CUR};
   assign glyph_base_in = {glyph_idx[6:0], 2'b00} + {2'b00, glyph_idx[6:0]};

   assign x0_sel = (req_action == ACT_DRAW_POS) ? req_pos_x : cursor_x_ff;
   assign y0_sel = (req_action == ACT_DRAW_POS) ? req_pos_y : cursor_y_ff;

   // The cursor wraps when the next cell would pass the width.
   assign x_wrap_test = {x0_sel[9], x0_sel} + 11'(2 * CELL_ADVANCE);
   assign y_next      = {y0_sel[8], y0_sel} + 10'(LINE_ADVANCE);

   always_comb begin
      cursor_x_in = x0_sel + 10'(CELL_ADVANCE);
      cursor_y_in = y0_sel;
      if (!x_wrap_test[10] && (x_wrap_test > 11'(SCREEN_WIDTH))) begin
         cursor_x_in = '0;
         if (!y_next[9] && (y_next > 10'(Y_TOP))) begin
            cursor_y_in = 9'(Y_TOP);
         end else begin
            cursor_y_in = y_next[8:0];
         end
      end
   end

   assign sts.start_draw = is_draw && code_ok;

   // Start address of the glyph's top left pixel, modulo the address width.
   logic [13:0] y_ext;
   logic [27:0] y_prod;
   logic [13:0] start_addr;

   assign y_ext      = {{5{y0_ff[8]}}, y0_ff};
   assign y_prod     = {14'd0, y_ext} * 28'(SCREEN_WIDTH);
   assign start_addr = y_prod[13:0] + {{4{x0_ff[9]}}, x0_ff};

   // Pixel position and clipping of the current scan position.
   logic [10:0] px, px_next;
   logic [9:0]  py, py_next;
   logic        col_in, row_in, inside_px, last_px, slot_free, load_out;
   logic [7:0]  cur_col;

   assign px      = {x0_ff[9], x0_ff} + {8'd0, col_ff};
   assign py      = {y0_ff[8], y0_ff} + {7'd0, row_ff};
   assign px_next = px + 11'd1;
   assign py_next = py + 10'd1;
   assign col_in  = !px[10] && (px < 11'(SCREEN_WIDTH));
   assign row_in  = !py[9] && (py < 10'(SCREEN_HEIGHT));
   assign inside_px = col_in && row_in;
   // Visible rows and columns are contiguous, so the last visible pixel is the one
   // whose row and column are each the last visible of their kind.
   assign last_px = ((row_ff == LAST_ROW) || (py_next >= 10'(SCREEN_HEIGHT)))
                    && ((col_ff == LAST_COL) || (px_next >= 11'(SCREEN_WIDTH)));
   assign cur_col   = col_bits_ff[col_ff];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load_out  = cmd.draw_en && inside_px && slot_free;

   assign sts.fetch_last  = (fetch_cnt_ff == 3'(GLYPH_COLS));
   assign sts.pixel_step  = !inside_px || slot_free;
   assign sts.pixel_final = (row_ff == LAST_ROW) && (col_ff == LAST_COL);

   always_ff @(posedge clock) begin
      if (cmd.capture && (req_action == ACT_LOAD)
          && ({1'b0, req_font_address} < 10'(MEM_DEPTH))) begin
         glyph_mem[req_font_address[MEM_AW-1:0]] <= req_font_byte;
      end
      if (cmd.fetch_en && (fetch_cnt_ff < 3'(GLYPH_COLS))) begin
         rd_data_ff <= glyph_mem[MEM_AW'(glyph_base_ff + {6'd0, fetch_cnt_ff})];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x0_ff         <= x0_sel;
         y0_ff         <= y0_sel;
         fg_ff         <= req_fg_value;
         bg_ff         <= req_bg_value;
         glyph_base_ff <= glyph_base_in;
      end
      if (cmd.fetch_en) begin
         if (fetch_cnt_ff != 3'd0) begin
            col_bits_ff[fetch_cnt_ff - 3'd1] <= rd_data_ff;
         end else begin
            addr_ff <= start_addr;
         end
      end
      if (cmd.draw_en && sts.pixel_step) begin
         if (col_ff == LAST_COL) begin
            addr_ff <= addr_ff + ROW_STEP;
         end else begin
            addr_ff <= addr_ff + 14'd1;
         end
      end
      if (load_out) begin
         rsp_addr_ff  <= addr_ff;
         rsp_value_ff <= cur_col[row_ff] ? fg_ff : bg_ff;
         rsp_last_ff  <= last_px;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         fetch_cnt_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            fetch_cnt_ff <= '0;
            row_ff       <= '0;
            col_ff       <= '0;
            if (is_draw) begin
               cursor_x_ff <= cursor_x_in;
               cursor_y_ff <= cursor_y_in;
            end
         end
         if (cmd.fetch_en && !sts.fetch_last) begin
            fetch_cnt_ff <= fetch_cnt_ff + 3'd1;
         end
         if (cmd.draw_en && sts.pixel_step && !sts.pixel_final) begin
            if (col_ff == LAST_COL) begin
               col_ff <= '0;
               row_ff <= row_ff + 3'd1;
            end else begin
               col_ff <= col_ff + 3'd1;
            end
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_value   = rsp_value_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW) && (col_ff <= LAST_COL) && (fetch_cnt_ff <= 3'(GLYPH_COLS)))
      else $error("scan counter out of range");

   // Only clipped positions may follow the last pixel of a character.
   assert property (@(posedge clock) disable iff (reset)
      load_out && last_px |=> !(cmd.draw_en && inside_px))
      else $error("visible pixel after the last pixel");

   assert property (@(posedge clock) disable iff (reset)
      cmd.draw_en && inside_px && !slot_free |=> cmd.draw_en && $stable(row_ff)
      && $stable(col_ff))
      else $error("visible pixel skipped while the output was full");

endmodule

### rtl/core/glyph_text_renderer_top.sv
// A load item, an unused action and a draw of a non-drawable code are accepted in idle.
// A drawable character goes through the accept, a fetch phase reading its five glyph
// columns from the single-port glyph memory, and a scan of its 35 glyph positions,
// visible or clipped; the output register takes a pixel item at each visible position.
// Reset clears the controller, the scan counters, the cursor and the output valid;
// the glyph memory keeps its contents and is undefined until loaded.
module glyph_text_renderer_top
   import gtr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 255,
   parameter int SCREEN_HEIGHT = 64,
   parameter int GLYPH_COUNT   = 96
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [8:0]        req_font_address,
   input  logic [7:0]        req_font_byte,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_fg_value,
   input  logic [7:0]        req_bg_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [13:0]       rsp_pixel_address,
   output logic [7:0]        rsp_pixel_value,
   output logic              rsp_last_pixel
);

   gtr_cmd_type cmd;
   gtr_sts_type sts;

   gtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gtr_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .GLYPH_COUNT   (GLYPH_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_font_address  (req_font_address),
      .req_font_byte     (req_font_byte),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_char_code     (req_char_code),
      .req_fg_value      (req_fg_value),
      .req_bg_value      (req_bg_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

### test/glyph_text_renderer_top_tb.sv
module glyph_text_renderer_top_tb
   import gtr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W       = 255;
   localparam int SCREEN_H       = 64;
   localparam int GLYPHS         = 96;
   localparam int FONT_DEPTH     = GLYPHS * GLYPH_COLS;
   localparam int ITEMS_PER_PASS = 160;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 4000;

   // Action code 3 is not decoded by the block.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]        action;
      logic [8:0]        font_address;
      logic [7:0]        font_byte;
      logic signed [9:0] pos_x;
      logic signed [8:0] pos_y;
      logic [7:0]        char_code;
      logic [7:0]        fg_value;
      logic [7:0]        bg_value;
   } text_cmd_type;

   typedef struct {
      logic [13:0] address;
      logic [7:0]  value;
      logic        last;
   } pixel_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_action = '0;
   logic [8:0]        req_font_address = '0;
   logic [7:0]        req_font_byte = '0;
   logic signed [9:0] req_pos_x = '0;
   logic signed [8:0] req_pos_y = '0;
   logic [7:0]        req_char_code = '0;
   logic [7:0]        req_fg_value = '0;
   logic [7:0]        req_bg_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [13:0]       rsp_pixel_address;
   logic [7:0]        rsp_pixel_value;
   logic              rsp_last_pixel;

   // Stimulus side.
   text_cmd_type cmd_queue [$];
   text_cmd_type next_cmd;
   bit           glyph_written [FONT_DEPTH];
   int           send_idle_pct = 16;
   int           recv_idle_pct = 77;
   int           queued_count  = 0;
   logic         req_accepted = 1'b0;

   // Prediction side: its own copy of the glyph memory and the cursor.
   logic [7:0]   glyph_store [FONT_DEPTH];
   int           cursor_col = 0;
   int           cursor_row = 0;
   pixel_type    pixel_fifo [$];
   text_cmd_type accepted_cmd;
   pixel_type    want;

   int error_count    = 0;
   int idle_cycles    = 0;
   int loads_seen     = 0;
   int draws_seen     = 0;
   int skipped_seen   = 0;
   int wraps_seen     = 0;
   int pixels_checked = 0;

   glyph_text_renderer_top #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H),
      .GLYPH_COUNT  (GLYPHS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_font_address (req_font_address),
      .req_font_byte    (req_font_byte),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_char_code    (req_char_code),
      .req_fg_value     (req_fg_value),
      .req_bg_value     (req_bg_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_address(rsp_pixel_address),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the pixel writes of one accepted item: a load updates the glyph copy, a draw moves the cursor.
   task automatic render_item(input text_cmd_type c);
      int        x0;
      int        y0;
      int        base;
      int        py;
      int        px;
      pixel_type batch [$];
      pixel_type pix;
      if (c.action == ACT_LOAD) begin
         loads_seen++;
         if (c.font_address < FONT_DEPTH) begin
            glyph_store[c.font_address] = c.font_byte;
         end
         return;
      end
      if (c.action != ACT_DRAW_POS && c.action != ACT_DRAW_CUR) begin
         return;
      end
      draws_seen++;
      if (c.action == ACT_DRAW_POS) begin
         x0 = $signed(c.pos_x);
         y0 = $signed(c.pos_y);
      end else begin
         x0 = cursor_col;
         y0 = cursor_row;
      end
      if (c.char_code >= FIRST_CODE && c.char_code < END_CODE) begin
         base = (int'(c.char_code) - int'(FIRST_CODE)) * GLYPH_COLS;
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            py = y0 + r;
            for (int k = 0; k < GLYPH_COLS; k++) begin
               px = x0 + k;
               if (py >= 0 && py < SCREEN_H && px >= 0 && px < SCREEN_W) begin
                  pix.address = 14'(py * SCREEN_W + px);
                  pix.value   = glyph_store[base + k][r] ? c.fg_value : c.bg_value;
                  pix.last    = 1'b0;
                  batch.push_back(pix);
               end
            end
         end
         if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
         end
         foreach (batch[i]) begin
            pixel_fifo.push_back(batch[i]);
         end
      end else begin
         skipped_seen++;
      end
      x0 += CELL_ADVANCE;
      if (x0 + CELL_ADVANCE > SCREEN_W) begin
         wraps_seen++;
         x0 = 0;
         y0 += LINE_ADVANCE;
         if (y0 > Y_TOP) begin
            y0 = Y_TOP;
         end
      end
      cursor_col = x0;
      cursor_row = y0;
   endtask

   // Driver: a new item goes out only once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = cmd_queue.pop_front();
            req_valid        <= 1'b1;
            req_action       <= next_cmd.action;
            req_font_address <= next_cmd.font_address;
            req_font_byte    <= next_cmd.font_byte;
            req_pos_x        <= next_cmd.pos_x;
            req_pos_y        <= next_cmd.pos_y;
            req_char_code    <= next_cmd.char_code;
            req_fg_value     <= next_cmd.fg_value;
            req_bg_value     <= next_cmd.bg_value;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: results are checked before a newly accepted item is predicted,
   // as a result in the same cycle always belongs to an earlier item.
   always @(posedge clock) begin
      if (reset) begin
         req_accepted <= 1'b0;
         idle_cycles  <= 0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            pixels_checked++;
            if (pixel_fifo.size() == 0) begin
               error_count++;
               $display("%0t: unexpected pixel: expected none, got %0d/%02h/%0b",
                        $time, rsp_pixel_address, rsp_pixel_value, rsp_last_pixel);
            end else begin
               want = pixel_fifo.pop_front();
               if (rsp_pixel_address !== want.address || rsp_pixel_value !== want.value ||
                   rsp_last_pixel !== want.last) begin
                  error_count++;
                  $display("%0t: pixel mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                           $time, want.address, want.value, want.last,
                           rsp_pixel_address, rsp_pixel_value, rsp_last_pixel);
               end
            end
         end
         if (req_valid && req_ready) begin
            accepted_cmd.action       = req_action;
            accepted_cmd.font_address = req_font_address;
            accepted_cmd.font_byte    = req_font_byte;
            accepted_cmd.pos_x        = req_pos_x;
            accepted_cmd.pos_y        = req_pos_y;
            accepted_cmd.char_code    = req_char_code;
            accepted_cmd.fg_value     = req_fg_value;
            accepted_cmd.bg_value     = req_bg_value;
            render_item(accepted_cmd);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic text_cmd_type random_cmd();
      text_cmd_type c;
      c.action       = 2'($urandom_range(3));
      c.font_address = 9'($urandom);
      c.font_byte    = 8'($urandom);
      c.pos_x        = 10'($urandom);
      c.pos_y        = 9'($urandom);
      c.char_code    = 8'($urandom);
      c.fg_value     = 8'($urandom);
      c.bg_value     = 8'($urandom);
      return c;
   endfunction

   function automatic bit glyph_ready(input logic [7:0] code);
      int base;
      base = (int'(code) - int'(FIRST_CODE)) * GLYPH_COLS;
      for (int k = 0; k < GLYPH_COLS; k++) begin
         if (!glyph_written[base + k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Mostly drawable codes, with the odd code from the whole byte range.
   function automatic logic [7:0] pick_code();
      if ($urandom_range(4) == 0) begin
         return 8'($urandom);
      end
      return 8'($urandom_range(127, 32));
   endfunction

   task automatic queue_cmd(input text_cmd_type c);
      if (c.action == ACT_LOAD && c.font_address < FONT_DEPTH) begin
         glyph_written[c.font_address] = 1'b1;
      end
      cmd_queue.push_back(c);
      queued_count++;
   endtask

   task automatic load_byte(input int address, input logic [7:0] value);
      text_cmd_type c;
      c = random_cmd();
      c.action       = ACT_LOAD;
      c.font_address = 9'(address);
      c.font_byte    = value;
      queue_cmd(c);
   endtask

   // A drawable glyph is always loaded in full before it is first drawn, so
   // that no unwritten glyph byte is ever read.
   task automatic put_draw(input logic [1:0] act, input logic [7:0] code,
                           input logic signed [9:0] x, input logic signed [8:0] y,
                           input logic [7:0] fg, input logic [7:0] bg);
      text_cmd_type c;
      int           base;
      if (code >= FIRST_CODE && code < END_CODE && !glyph_ready(code)) begin
         base = (int'(code) - int'(FIRST_CODE)) * GLYPH_COLS;
         for (int k = 0; k < GLYPH_COLS; k++) begin
            load_byte(base + k, 8'($urandom));
         end
      end
      c = random_cmd();
      c.action    = act;
      c.char_code = code;
      c.pos_x     = x;
      c.pos_y     = y;
      c.fg_value  = fg;
      c.bg_value  = bg;
      queue_cmd(c);
   endtask

   task automatic settle();
      @(posedge clock);
      #0.5;
   endtask

   initial begin
      text_cmd_type      c;
      int                pick;
      int                run_len;
      logic signed [9:0] x;
      logic signed [8:0] y;

      // Space and the last drawable code get fixed column patterns.
      load_byte(0, 8'h00);
      load_byte(1, 8'hFF);
      load_byte(2, 8'h55);
      load_byte(3, 8'hAA);
      load_byte(4, 8'h7F);
      load_byte(475, 8'h01);
      load_byte(476, 8'h40);
      load_byte(477, 8'h80);
      load_byte(478, 8'h3E);
      load_byte(479, 8'hFE);
      load_byte(480, 8'hFF);
      load_byte(511, 8'hFF);
      c = random_cmd();
      c.action = ACT_UNUSED;
      queue_cmd(c);
      put_draw(ACT_DRAW_POS, 8'h20, 10'sd0, 9'sd0, 8'hFF, 8'h00);
      // Clipped on the right and at the bottom, then wrapping off screen.
      put_draw(ACT_DRAW_POS, 8'h7F, 10'sd252, 9'sd60, 8'h00, 8'hFF);
      put_draw(ACT_DRAW_CUR, 8'h7F, 10'sd0, 9'sd0, 8'hA5, 8'h5A);
      put_draw(ACT_DRAW_POS, 8'h20, -10'sd3, -9'sd4, 8'hFF, 8'h00);
      put_draw(ACT_DRAW_POS, 8'h7F, 10'sh200, 9'sh100, 8'hFF, 8'h00);
      // Entirely off screen, and the cursor row saturates.
      put_draw(ACT_DRAW_POS, 8'h20, 10'sd511, 9'sd255, 8'hFF, 8'h00);
      put_draw(ACT_DRAW_POS, 8'h1F, 10'sd10, 9'sd10, 8'hFF, 8'h00);
      put_draw(ACT_DRAW_POS, 8'h80, 10'sd10, 9'sd10, 8'hFF, 8'h00);
      put_draw(ACT_DRAW_CUR, 8'hFF, 10'sd0, 9'sd0, 8'hFF, 8'h00);
      put_draw(ACT_DRAW_CUR, 8'h00, 10'sd0, 9'sd0, 8'hFF, 8'h00);
      // The last two cells that fit a line, then the wrap to the next line.
      put_draw(ACT_DRAW_POS, 8'h7F, 10'sd243, 9'sd0, 8'h3C, 8'hC3);
      put_draw(ACT_DRAW_CUR, 8'h20, 10'sd0, 9'sd0, 8'hFF, 8'h00);
      put_draw(ACT_DRAW_CUR, 8'h7F, 10'sd0, 9'sd0, 8'h00, 8'hFF);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int pass = 0; pass < 3; pass++) begin
         settle();
         if (pass == 1) begin
            send_idle_pct = 77;
            recv_idle_pct = 16;
         end else if (pass == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         while (queued_count < (pass + 1) * ITEMS_PER_PASS) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               c = random_cmd();
               c.action = ACT_LOAD;
               if ($urandom_range(9) == 0) begin
                  c.font_address = 9'($urandom_range(511, FONT_DEPTH));
               end else begin
                  c.font_address = 9'($urandom_range(FONT_DEPTH - 1));
               end
               queue_cmd(c);
            end else if (pick < 16) begin
               c = random_cmd();
               c.action = ACT_UNUSED;
               queue_cmd(c);
            end else if (pick < 24) begin
               // A run of text at the cursor, the usual way the block is driven.
               run_len = $urandom_range(10, 3);
               repeat (run_len) begin
                  put_draw(ACT_DRAW_CUR, pick_code(), 10'($urandom), 9'($urandom),
                           8'($urandom), 8'($urandom));
               end
            end else begin
               if ($urandom_range(3) == 0) begin
                  x = 10'($urandom);
                  y = 9'($urandom);
               end else begin
                  x = 10'(int'($urandom_range(264)) - 6);
                  y = 9'(int'($urandom_range(74)) - 8);
               end
               put_draw((pick < 60) ? ACT_DRAW_POS : ACT_DRAW_CUR, pick_code(), x, y,
                        8'($urandom), 8'($urandom));
            end
         end
         do begin
            settle();
         end while (cmd_queue.size() != 0 || req_valid || pixel_fifo.size() != 0);
      end

      repeat (DRAIN_CYCLES) settle();
      if (pixel_fifo.size() != 0) begin
         error_count++;
         $display("%0t: %0d pixel writes expected but never seen", $time, pixel_fifo.size());
      end
      $display("Covered %0d loads, %0d draws (%0d skipped codes), %0d line wraps.",
               loads_seen, draws_seen, skipped_seen, wraps_seen);
      $display("Checked %0d pixel writes under three handshake pacing patterns.", pixels_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
